FILE: hdl/tvc_pkg.sv
// token value classifier package: result codes, character constants,
// recognizer state types and character class functions
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tvc_pkg;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_IPV4  = 3'd1,
    KIND_MAC   = 3'd2,
    KIND_IPV6  = 3'd3,
    KIND_EMAIL = 3'd4,
    KIND_DATE  = 3'd5
  } kind_e;

  localparam logic [1:0] NC_OTHER  = 2'd0;
  localparam logic [1:0] NC_IPADDR = 2'd1;
  localparam logic [1:0] NC_SCALAR = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  localparam logic [4:0] COUNT_MAX = 5'd31;
  localparam logic [4:0] MAC_LEN   = 5'd17;
  localparam logic [4:0] DATE_LEN  = 5'd10;
  localparam logic [9:0] OCTET_MAX = 10'd255;
  localparam logic [2:0] V4_OCTETS = 3'd4;
  localparam logic [3:0] V6_GROUPS = 4'd8;
  localparam logic [2:0] V6_GLEN   = 3'd4;
  localparam logic [6:0] MONTH_MAX = 7'd12;
  localparam logic [6:0] DAY_MAX   = 7'd31;

  localparam logic [1:0] PH_LOCAL  = 2'd0;
  localparam logic [1:0] PH_DOMAIN = 2'd1;
  localparam logic [1:0] PH_DOT    = 2'd2;
  localparam logic [1:0] PH_TAIL   = 2'd3;

  typedef struct packed {
    logic       ok;
    logic [2:0] octets;
    logic [1:0] len;
    logic [9:0] val;
  } v4_t;

  typedef struct packed {
    logic ok;
    logic colon;
  } mac_t;

  typedef struct packed {
    logic       ok;
    logic       grp_ok;
    logic       colon;
    logic       dcolon;
    logic       prev_colon;
    logic [2:0] len;
    logic [3:0] groups;
  } v6_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] phase;
    logic       dom_nonempty;
  } mail_t;

  typedef struct packed {
    logic       ok;
    logic [6:0] month;
    logic [6:0] day;
  } date_t;

  localparam v4_t   V4_RST   = '{ok: 1'b1, octets: '0, len: '0, val: '0};
  localparam mac_t  MAC_RST  = '{ok: 1'b1, colon: 1'b0};
  localparam v6_t   V6_RST   = '{ok: 1'b1, grp_ok: 1'b1, colon: 1'b0, dcolon: 1'b0,
                                 prev_colon: 1'b0, len: '0, groups: '0};
  localparam mail_t MAIL_RST = '{ok: 1'b1, phase: PH_LOCAL, dom_nonempty: 1'b0};
  localparam date_t DATE_RST = '{ok: 1'b1, month: '0, day: '0};

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dig(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_dig(c) || ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

endpackage

`default_nettype wire

FILE: hdl/token_value_classifier_top.sv
// token value classifier top: byte input register, five recognizers, result register
// depends on tvc_pkg
// a terminator byte passes the byte input register, then its result is loaded into the result register
// throughput: one byte per cycle while the input is not stalled; set by the single recognizer update stage
// a terminator waits in the input register only while an unread result is stalled
// reset clears all recognizer state, the byte register and the result register
`timescale 1ns / 1ps
`default_nettype none

module token_value_classifier_top
  import tvc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] ch_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      kind_o,
  output logic [1:0]      node_class_o
);

  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       proc;
  logic       term;

  logic [4:0] cnt_q, cnt_d;
  v4_t        v4_q, v4_d;
  mac_t       mac_q, mac_d;
  v6_t        v6_q, v6_d;
  mail_t      mail_q, mail_d;
  date_t      date_q, date_d;

  logic       out_valid_q, out_valid_d;
  kind_e      kind_q, kind_d;
  logic [1:0] nc_q, nc_d;

  assign term       = (ch_q == CH_NUL);
  assign in_stall_o = in_valid_q && term && out_valid_q && out_stall_i;
  assign proc       = in_valid_q && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      ch_q       <= '0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
      ch_q       <= ch_i;
    end
  end

  // per-byte recognizer update
  always_comb begin
    logic        legal;
    logic [4:0]  pos;
    pos    = cnt_q;
    cnt_d  = cnt_q;
    v4_d   = v4_q;
    mac_d  = mac_q;
    v6_d   = v6_q;
    mail_d = mail_q;
    date_d = date_q;
    legal  = 1'b0;
    if (proc) begin
      if (term) begin
        cnt_d  = '0;
        v4_d   = V4_RST;
        mac_d  = MAC_RST;
        v6_d   = V6_RST;
        mail_d = MAIL_RST;
        date_d = DATE_RST;
      end else begin
        if (cnt_q != COUNT_MAX) begin
          cnt_d = cnt_q + 5'd1;
        end

        // ipv4
        if (is_dig(ch_q)) begin
          if (v4_q.len == 2'd3) begin
            v4_d.ok = 1'b0;
          end else begin
            v4_d.val = 10'((v4_q.val << 3) + (v4_q.val << 1) + {6'b0, ch_q[3:0]});
            v4_d.len = v4_q.len + 2'd1;
          end
        end else if (ch_q == CH_DOT) begin
          if (v4_q.len == '0 || v4_q.val > OCTET_MAX || v4_q.octets >= V4_OCTETS) begin
            v4_d.ok = 1'b0;
          end else begin
            v4_d.octets = v4_q.octets + 3'd1;
          end
          v4_d.len = '0;
          v4_d.val = '0;
        end else begin
          v4_d.ok = 1'b0;
        end

        // mac
        if (pos >= MAC_LEN) begin
          mac_d.ok = 1'b0;
        end else if (pos == 5'd2) begin
          if (ch_q == CH_COLON) begin
            mac_d.colon = 1'b1;
          end else if (ch_q == CH_DASH) begin
            mac_d.colon = 1'b0;
          end else begin
            mac_d.ok = 1'b0;
          end
        end else if (pos == 5'd5 || pos == 5'd8 || pos == 5'd11 || pos == 5'd14) begin
          if (ch_q != (mac_q.colon ? CH_COLON : CH_DASH)) begin
            mac_d.ok = 1'b0;
          end
        end else if (!is_hex(ch_q)) begin
          mac_d.ok = 1'b0;
        end

        // ipv6
        if (ch_q == CH_COLON) begin
          if (v6_q.prev_colon) begin
            v6_d.dcolon = 1'b1;
          end
          v6_d.colon      = 1'b1;
          v6_d.prev_colon = 1'b1;
          if (v6_q.len == '0 || v6_q.len > V6_GLEN || v6_q.groups >= V6_GROUPS) begin
            v6_d.grp_ok = 1'b0;
          end else begin
            v6_d.groups = v6_q.groups + 4'd1;
          end
          v6_d.len = '0;
        end else begin
          v6_d.prev_colon = 1'b0;
          if (!is_hex(ch_q)) begin
            v6_d.ok = 1'b0;
          end else if (v6_q.len >= V6_GLEN) begin
            v6_d.grp_ok = 1'b0;
          end else begin
            v6_d.len = v6_q.len + 3'd1;
          end
        end

        // email
        legal = (ch_q == CH_AT) || (ch_q == CH_DOT) || (ch_q == CH_DASH) ||
                (ch_q == CH_UNDER) || (ch_q == CH_PLUS) || is_alnum(ch_q);
        if (!legal) begin
          mail_d.ok = 1'b0;
        end
        if (ch_q == CH_AT) begin
          if (mail_q.phase != PH_LOCAL || pos == '0) begin
            mail_d.ok = 1'b0;
          end
          mail_d.phase        = PH_DOMAIN;
          mail_d.dom_nonempty = 1'b0;
        end else if (mail_q.phase == PH_DOMAIN) begin
          if (ch_q == CH_DOT) begin
            if (!mail_q.dom_nonempty) begin
              mail_d.ok = 1'b0;
            end
            mail_d.phase = PH_DOT;
          end else begin
            mail_d.dom_nonempty = 1'b1;
          end
        end else if (mail_q.phase == PH_DOT) begin
          mail_d.phase = PH_TAIL;
        end

        // iso date
        if (pos >= DATE_LEN) begin
          date_d.ok = 1'b0;
        end else if (pos == 5'd4 || pos == 5'd7) begin
          if (ch_q != CH_DASH) begin
            date_d.ok = 1'b0;
          end
        end else if (!is_dig(ch_q)) begin
          date_d.ok = 1'b0;
        end else if (pos == 5'd5 || pos == 5'd6) begin
          date_d.month = 7'((date_q.month << 3) + (date_q.month << 1) + {3'b0, ch_q[3:0]});
        end else if (pos == 5'd8 || pos == 5'd9) begin
          date_d.day = 7'((date_q.day << 3) + (date_q.day << 1) + {3'b0, ch_q[3:0]});
        end
      end
    end
  end

  // terminator decision in priority order
  always_comb begin
    logic is_v4;
    logic is_mac;
    logic is_v6;
    logic is_mail;
    logic is_date;
    if (v4_q.len != '0) begin
      is_v4 = v4_q.ok && v4_q.val <= OCTET_MAX && v4_q.octets == (V4_OCTETS - 3'd1);
    end else begin
      is_v4 = v4_q.ok && v4_q.octets == V4_OCTETS;
    end
    is_mac  = mac_q.ok && cnt_q == MAC_LEN;
    is_v6   = v6_q.ok && v6_q.colon &&
              (v6_q.dcolon || (v6_q.grp_ok && v6_q.len != '0 && v6_q.len <= V6_GLEN &&
                               v6_q.groups == (V6_GROUPS - 4'd1)));
    is_mail = mail_q.ok && mail_q.phase == PH_TAIL;
    is_date = date_q.ok && cnt_q == DATE_LEN &&
              date_q.month != '0 && date_q.month <= MONTH_MAX &&
              date_q.day != '0 && date_q.day <= DAY_MAX;
    kind_d = KIND_NONE;
    nc_d   = NC_OTHER;
    priority if (cnt_q == '0) begin
      kind_d = KIND_NONE;
    end else if (is_v4) begin
      kind_d = KIND_IPV4;
      nc_d   = NC_IPADDR;
    end else if (is_mac) begin
      kind_d = KIND_MAC;
      nc_d   = NC_SCALAR;
    end else if (is_v6) begin
      kind_d = KIND_IPV6;
      nc_d   = NC_IPADDR;
    end else if (is_mail) begin
      kind_d = KIND_EMAIL;
      nc_d   = NC_SCALAR;
    end else if (is_date) begin
      kind_d = KIND_DATE;
      nc_d   = NC_SCALAR;
    end else begin
      kind_d = KIND_NONE;
    end
  end

  assign out_valid_d = (proc && term) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      v4_q        <= V4_RST;
      mac_q       <= MAC_RST;
      v6_q        <= V6_RST;
      mail_q      <= MAIL_RST;
      date_q      <= DATE_RST;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_NONE;
      nc_q        <= NC_OTHER;
    end else begin
      cnt_q       <= cnt_d;
      v4_q        <= v4_d;
      mac_q       <= mac_d;
      v6_q        <= v6_d;
      mail_q      <= mail_d;
      date_q      <= date_d;
      out_valid_q <= out_valid_d;
      if (proc && term) begin
        kind_q <= kind_d;
        nc_q   <= nc_d;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign node_class_o = nc_q;

endmodule

`default_nettype wire
